// ===== sv/urc_pkg.sv =====
package urc_pkg;

  // Number of letter and combining-mark pairs that recompose.
  localparam int unsigned PairCount = 53;

  // Result queue depth and the largest number of results from one request.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MaxResults = 3;

  // Byte forms used by the recomposition.
  localparam logic [7:0] CombLeadMask = 8'hFC;
  localparam logic [7:0] CombLeadForm = 8'hCC;
  localparam logic [7:0] Utf8Lead2    = 8'hC0;
  localparam logic [7:0] Utf8Cont     = 8'h80;

  typedef struct packed {
    logic [7:0]  letter;
    logic [10:0] mark;
    logic [7:0]  composed;
  } pair_t;

  // One result byte with its end-of-string flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  // Results of one request, the first in item[0].
  typedef struct packed {
    logic [1:0]           num;
    res_t [MaxResults-1:0] item;
  } res_bundle_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] composed;
  } lookup_t;

  localparam pair_t PAIRS [PairCount] = '{
    '{8'h41, 11'h300, 8'hC0}, '{8'h41, 11'h301, 8'hC1}, '{8'h41, 11'h302, 8'hC2},
    '{8'h41, 11'h303, 8'hC3}, '{8'h41, 11'h308, 8'hC4}, '{8'h41, 11'h30A, 8'hC5},
    '{8'h43, 11'h327, 8'hC7}, '{8'h45, 11'h300, 8'hC8}, '{8'h45, 11'h301, 8'hC9},
    '{8'h45, 11'h302, 8'hCA}, '{8'h45, 11'h308, 8'hCB}, '{8'h49, 11'h300, 8'hCC},
    '{8'h49, 11'h301, 8'hCD}, '{8'h49, 11'h302, 8'hCE}, '{8'h49, 11'h308, 8'hCF},
    '{8'h4E, 11'h303, 8'hD1}, '{8'h4F, 11'h300, 8'hD2}, '{8'h4F, 11'h301, 8'hD3},
    '{8'h4F, 11'h302, 8'hD4}, '{8'h4F, 11'h303, 8'hD5}, '{8'h4F, 11'h308, 8'hD6},
    '{8'h55, 11'h300, 8'hD9}, '{8'h55, 11'h301, 8'hDA}, '{8'h55, 11'h302, 8'hDB},
    '{8'h55, 11'h308, 8'hDC}, '{8'h59, 11'h301, 8'hDD}, '{8'h61, 11'h300, 8'hE0},
    '{8'h61, 11'h301, 8'hE1}, '{8'h61, 11'h302, 8'hE2}, '{8'h61, 11'h303, 8'hE3},
    '{8'h61, 11'h308, 8'hE4}, '{8'h61, 11'h30A, 8'hE5}, '{8'h63, 11'h327, 8'hE7},
    '{8'h65, 11'h300, 8'hE8}, '{8'h65, 11'h301, 8'hE9}, '{8'h65, 11'h302, 8'hEA},
    '{8'h65, 11'h308, 8'hEB}, '{8'h69, 11'h300, 8'hEC}, '{8'h69, 11'h301, 8'hED},
    '{8'h69, 11'h302, 8'hEE}, '{8'h69, 11'h308, 8'hEF}, '{8'h6E, 11'h303, 8'hF1},
    '{8'h6F, 11'h300, 8'hF2}, '{8'h6F, 11'h301, 8'hF3}, '{8'h6F, 11'h302, 8'hF4},
    '{8'h6F, 11'h303, 8'hF5}, '{8'h6F, 11'h308, 8'hF6}, '{8'h75, 11'h300, 8'hF9},
    '{8'h75, 11'h301, 8'hFA}, '{8'h75, 11'h302, 8'hFB}, '{8'h75, 11'h308, 8'hFC},
    '{8'h79, 11'h301, 8'hFD}, '{8'h79, 11'h308, 8'hFF}
  };

  // Parallel match of a letter and a combining mark against every pair.
  function automatic lookup_t accent_lookup(logic [7:0] letter, logic [10:0] mark);
    lookup_t res;
    res = '0;
    for (int k = 0; k < PairCount; k++) begin
      if (PAIRS[k].letter == letter && PAIRS[k].mark == mark) begin
        res.hit      = 1'b1;
        res.composed = res.composed | PAIRS[k].composed;
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/utf8_accent_recomposer.sv =====
// A byte accepted into the input register is worked on once the queue has room for its results,
// which are written into the queue and offered from there.
// Throughput: one input byte per cycle and one output byte per cycle; a recomposed letter
// gives two output bytes and a flush up to three, drained from a four-entry queue. The input
// stalls while the queue, less the byte leaving it in that cycle, holds more than one byte.
// Reset: synchronous, active low; it empties the input register, the window and the queue.
module utf8_accent_recomposer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic                 in_last_r;
  logic                 go;
  logic                 room;
  urc_pkg::res_bundle_t results;
  urc_pkg::res_t        head;

  // The held request is worked on once the queue has space for its results.
  assign go        = in_valid_r && room;
  assign in_tready = !in_valid_r || go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  urc_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .byte_in (in_byte_r),
    .last_in (in_last_r),
    .results (results)
  );

  urc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (go),
    .push_data (results),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign out_tdata = head.data;
  assign out_tlast = head.last;

endmodule

// ===== sv/urc_step.sv =====
module urc_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [7:0]           byte_in,
  input  logic                 last_in,
  output urc_pkg::res_bundle_t results
);

  logic [7:0] win0_r, win1_r, win0_nxt, win1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Window update and result forming for one request.
  always_comb begin
    logic [7:0]       b0, b1, b2, m0, m1;
    logic [1:0]       mhave;
    logic [1:0]       n;
    logic [10:0]      mark;
    urc_pkg::lookup_t lk;
    urc_pkg::res_t [urc_pkg::MaxResults-1:0] res;

    b0 = win0_r;
    b1 = win1_r;
    b2 = byte_in;
    res = '0;
    n = 2'd0;
    mark = {b1[4:0], b2[5:0]};
    lk = urc_pkg::accent_lookup(b0, mark);

    // Fewer than two bytes waiting: the new byte joins the window.
    case (cnt_r)
      2'd0: begin
        m0 = byte_in;
        m1 = win1_r;
        mhave = 2'd1;
      end
      2'd1: begin
        m0 = win0_r;
        m1 = byte_in;
        mhave = 2'd2;
      end
      default: begin
        // Three bytes at hand: try to recompose, else pass the oldest on.
        if ((b1 & urc_pkg::CombLeadMask) == urc_pkg::CombLeadForm && lk.hit) begin
          res[0].data = urc_pkg::Utf8Lead2 | {6'd0, lk.composed[7:6]};
          res[1].data = urc_pkg::Utf8Cont | {2'd0, lk.composed[5:0]};
          n = 2'd2;
          m0 = b1;
          m1 = b2;
          mhave = 2'd0;
        end else begin
          res[0].data = b0;
          n = 2'd1;
          m0 = b1;
          m1 = b2;
          mhave = 2'd2;
        end
      end
    endcase

    // The final byte flushes whatever is left in the window.
    if (last_in) begin
      for (int i = 0; i < 2; i++) begin
        if (2'(i) < mhave) begin
          res[n].data = (i == 0) ? m0 : m1;
          n = n + 2'd1;
        end
      end
      if (n != 2'd0) begin
        res[n - 2'd1].last = 1'b1;
      end
      mhave = 2'd0;
    end

    results.num  = n;
    results.item = res;
    win0_nxt = (mhave > 2'd0) ? m0 : 8'd0;
    win1_nxt = (mhave > 2'd1) ? m1 : 8'd0;
    cnt_nxt  = mhave;
  end

  // Window registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= 8'd0;
      win1_r <= 8'd0;
      cnt_r  <= 2'd0;
    end else if (go) begin
      win0_r <= win0_nxt;
      win1_r <= win1_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== sv/urc_fifo.sv =====
module urc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  urc_pkg::res_bundle_t push_data,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output urc_pkg::res_t        out_data
);

  urc_pkg::res_t mem_r [urc_pkg::QueueDepth];
  logic [1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          pop;

  // A request may enter only when the queue can take its largest result set.
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= (3'd1 + {2'd0, pop}));
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[rd_ptr_r];

  // Pointer and fill arithmetic.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (push ? push_data.num : 2'd0);
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + (push ? {1'b0, push_data.num} : 3'd0) - {2'd0, pop};
  end

  // Queue storage: up to three entries written at once.
  always_ff @(posedge clk) begin
    for (int i = 0; i < urc_pkg::MaxResults; i++) begin
      if (push && 2'(i) < push_data.num) begin
        mem_r[wr_ptr_r + 2'(i)] <= push_data.item[i];
      end
    end
  end

  // Queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
